@@ hdl/sphit_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sphit_pkg: shared types and constants of the shape point hit test unit
// Coordinate format, tolerance register layout, primitive codes and the
// sequencer's phase and step encodings.
// ----------------------------------------------------------------------------
package sphit_pkg;

   localparam int COORD_WIDTH_DEF = 24;
   localparam int FRAC_BITS       = 8;
   localparam int TOL_WIDTH       = 23;
   // one page unit of tolerance after reset
   localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(1 << FRAC_BITS);

   typedef enum logic [1:0] {
      MODE_SEGMENT = 2'd0,
      MODE_ELLIPSE = 2'd1,
      MODE_QUAD    = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_LOAD,
      PH_RUN,
      PH_STORE,
      PH_CHECK,
      PH_DONE
   } phase_type;

   typedef enum logic [4:0] {
      SG_T2, SG_DOT0, SG_DOT1, SG_L20, SG_L21, SG_BRANCH,
      SG_NA0, SG_NA1, SG_NB0, SG_NB1,
      SG_CR0, SG_CR1, SG_CR2, SG_CR3,
      EL_CHK, EL_RXS, EL_RYS, EL_UU, EL_Q0, EL_VV, EL_Q1, EL_R,
      QD_FIN, FIN_W0, FIN_R, MISS
   } step_type;

   typedef enum logic [2:0] {
      DST_W0, DST_W1, DST_W2, DST_Q, DST_R
   } dst_type;

   typedef enum logic [1:0] {
      CMB_SET, CMB_ADD, CMB_SUB
   } cmb_type;

endpackage
`default_nettype wire

@@ hdl/shape_point_hit_test_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// shape_point_hit_test_unit: query point against a run of shape primitives
// Each request transfer carries one primitive (segment, ellipse bounds or
// quad corners) and the query point. Hits of a run are ORed and one
// response transfer with the result follows the item flagged last_item.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel req_*: valid/stall. req_stall is high while an item is
//   being worked; one item is in the unit at a time.
//   Response channel rsp_*: valid/stall, one transfer per run, driven from
//   an output register, so a waiting response does not block the next item
//   unless that item is itself the last of a run.
//   csr_write_enable/csr_write_data write hit_tolerance; write only while idle.
// Multiplier:
//   All products come from one shared shift-add multiplier that retires one
//   multiplier bit per cycle. Each product is a load step, a run that ends
//   when no set bit of the second operand is left, and a store step. A
//   segment takes 7 or 9 products, an ellipse 7; a quad, an unused mode or
//   a flat ellipse needs no product.
// Reset:
//   Synchronous, active high. Clears the sequencer, the run accumulator and
//   the response valid, and loads hit_tolerance with 1.0 (256).
// Stall:
//   A stalled response holds; a last item that finds the response register
//   still occupied waits in its final step until the transfer completes.
// ----------------------------------------------------------------------------
module shape_point_hit_test_unit #(
   parameter int COORD_WIDTH = sphit_pkg::COORD_WIDTH_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_write_enable,
   input  wire        [sphit_pkg::TOL_WIDTH-1:0] csr_write_data,
   input  wire                                   req_valid,
   output logic                                  req_stall,
   input  wire        [1:0]                      req_mode,
   input  wire signed [COORD_WIDTH-1:0]          req_point_x,
   input  wire signed [COORD_WIDTH-1:0]          req_point_y,
   input  wire signed [COORD_WIDTH-1:0]          req_first_x,
   input  wire signed [COORD_WIDTH-1:0]          req_first_y,
   input  wire signed [COORD_WIDTH-1:0]          req_second_x,
   input  wire signed [COORD_WIDTH-1:0]          req_second_y,
   input  wire signed [COORD_WIDTH-1:0]          req_third_x,
   input  wire signed [COORD_WIDTH-1:0]          req_third_y,
   input  wire signed [COORD_WIDTH-1:0]          req_fourth_x,
   input  wire signed [COORD_WIDTH-1:0]          req_fourth_y,
   input  wire                                   req_last_item,
   output logic                                  rsp_valid,
   input  wire                                   rsp_stall,
   output logic                                  rsp_hit
);
   import sphit_pkg::*;

   // operand registers: differences, ellipse terms or quad bounds
   localparam int AW = (COORD_WIDTH + 3 > TOL_WIDTH + 4) ? COORD_WIDTH + 3 : TOL_WIDTH + 4;
   // multiplier operand magnitude width
   localparam int MW = 2 * AW - 2;
   // wide accumulator width
   localparam int VW = 2 * MW + 2;

   phase_type phase_ff, phase_in;
   step_type  step_ff, step_in;
   logic      last_ff, last_in;
   logic      item_hit_ff, item_hit_in;
   logic      hit_so_far_ff, hit_so_far_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_hit_ff, rsp_hit_in;
   logic [TOL_WIDTH-1:0] tol_ff;

   logic signed [AW-1:0] a0_ff, a1_ff, a2_ff, a3_ff, a4_ff, a5_ff;
   logic signed [AW-1:0] a0_in, a1_in, a2_in, a3_in, a4_in, a5_in;
   logic signed [VW-1:0] w0_ff, w1_ff, w2_ff, q_ff, r_ff;
   logic signed [VW-1:0] w0_in, w1_in, w2_in, q_in, r_in;
   logic [2*MW-1:0] mcand_ff, mcand_in, prod_ff, prod_in;
   logic [MW-1:0]   mplier_ff, mplier_in;
   logic            neg_ff, neg_in;

   logic accept;
   logic start_check;
   step_type start_step;

   // per-step plan of the shared multiplier
   logic signed [VW-1:0] op_a, op_b, mag_a, mag_b;
   dst_type  plan_dst;
   cmb_type  plan_cmb;
   step_type plan_next;

   // check-step decisions
   logic     chk_hit;
   logic     chk_finish;
   step_type chk_next;

   // store path
   logic signed [VW-1:0] dst_old, store_base, store_prod, store_val;

   // capture terms
   logic signed [AW-1:0] px_e, py_e, ax_e, ay_e, bx_e, by_e;
   logic signed [AW-1:0] cx_e, cy_e, dx_e, dy_e, tol_a, ext_x, ext_y;
   logic                 out_free;

   function automatic logic signed [AW-1:0] min2(input logic signed [AW-1:0] p,
                                                 input logic signed [AW-1:0] q);
      return (p < q) ? p : q;
   endfunction

   function automatic logic signed [AW-1:0] max2(input logic signed [AW-1:0] p,
                                                 input logic signed [AW-1:0] q);
      return (p > q) ? p : q;
   endfunction

   assign req_stall = (phase_ff != PH_IDLE);
   assign accept    = req_valid && (phase_ff == PH_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // sign-extend the request coordinates to operand width
   always_comb begin
      px_e  = AW'(req_point_x);
      py_e  = AW'(req_point_y);
      ax_e  = AW'(req_first_x);
      ay_e  = AW'(req_first_y);
      bx_e  = AW'(req_second_x);
      by_e  = AW'(req_second_y);
      cx_e  = AW'(req_third_x);
      cy_e  = AW'(req_third_y);
      dx_e  = AW'(req_fourth_x);
      dy_e  = AW'(req_fourth_y);
      tol_a = signed'(AW'(tol_ff));
      ext_x = (bx_e >= ax_e) ? bx_e - ax_e : ax_e - bx_e;
      ext_y = (ay_e >= by_e) ? ay_e - by_e : by_e - ay_e;
   end

   // first step of each primitive kind; unused code is a plain miss
   always_comb begin
      unique case (mode_type'(req_mode))
         MODE_SEGMENT: begin
            start_step  = SG_T2;
            start_check = 1'b0;
         end
         MODE_ELLIPSE: begin
            start_step  = EL_CHK;
            start_check = 1'b1;
         end
         MODE_QUAD: begin
            start_step  = QD_FIN;
            start_check = 1'b1;
         end
         default: begin
            start_step  = MISS;
            start_check = 1'b1;
         end
      endcase
   end

   // multiplier plan: operands, destination, combine and follow-up step
   always_comb begin
      op_a      = '0;
      op_b      = '0;
      plan_dst  = DST_Q;
      plan_cmb  = CMB_SET;
      plan_next = MISS;
      unique case (step_ff)
         SG_T2: begin
            op_a = signed'(VW'(tol_ff)); op_b = signed'(VW'(tol_ff));
            plan_dst = DST_W0; plan_next = SG_DOT0;
         end
         SG_DOT0: begin
            op_a = VW'(a2_ff); op_b = VW'(a0_ff);
            plan_dst = DST_W1; plan_next = SG_DOT1;
         end
         SG_DOT1: begin
            op_a = VW'(a3_ff); op_b = VW'(a1_ff);
            plan_dst = DST_W1; plan_cmb = CMB_ADD; plan_next = SG_L20;
         end
         SG_L20: begin
            op_a = VW'(a0_ff); op_b = VW'(a0_ff);
            plan_dst = DST_W2; plan_next = SG_L21;
         end
         SG_L21: begin
            op_a = VW'(a1_ff); op_b = VW'(a1_ff);
            plan_dst = DST_W2; plan_cmb = CMB_ADD; plan_next = SG_BRANCH;
         end
         SG_NA0: begin
            op_a = VW'(a2_ff); op_b = VW'(a2_ff);
            plan_next = SG_NA1;
         end
         SG_NA1: begin
            op_a = VW'(a3_ff); op_b = VW'(a3_ff);
            plan_cmb = CMB_ADD; plan_next = FIN_W0;
         end
         SG_NB0: begin
            op_a = VW'(a4_ff); op_b = VW'(a4_ff);
            plan_next = SG_NB1;
         end
         SG_NB1: begin
            op_a = VW'(a5_ff); op_b = VW'(a5_ff);
            plan_cmb = CMB_ADD; plan_next = FIN_W0;
         end
         SG_CR0: begin
            op_a = VW'(a2_ff); op_b = VW'(a1_ff);
            plan_next = SG_CR1;
         end
         SG_CR1: begin
            op_a = VW'(a3_ff); op_b = VW'(a0_ff);
            plan_cmb = CMB_SUB; plan_next = SG_CR2;
         end
         SG_CR2: begin
            op_a = q_ff; op_b = q_ff;
            plan_next = SG_CR3;
         end
         SG_CR3: begin
            op_a = w0_ff; op_b = w2_ff;
            plan_dst = DST_R; plan_next = FIN_R;
         end
         EL_RXS: begin
            op_a = VW'(a2_ff); op_b = VW'(a2_ff);
            plan_dst = DST_W0; plan_next = EL_RYS;
         end
         EL_RYS: begin
            op_a = VW'(a3_ff); op_b = VW'(a3_ff);
            plan_dst = DST_W1; plan_next = EL_UU;
         end
         EL_UU: begin
            op_a = VW'(a0_ff); op_b = VW'(a0_ff);
            plan_dst = DST_W2; plan_next = EL_Q0;
         end
         EL_Q0: begin
            op_a = w2_ff; op_b = w1_ff;
            plan_next = EL_VV;
         end
         EL_VV: begin
            op_a = VW'(a1_ff); op_b = VW'(a1_ff);
            plan_dst = DST_W2; plan_next = EL_Q1;
         end
         EL_Q1: begin
            op_a = w2_ff; op_b = w0_ff;
            plan_cmb = CMB_ADD; plan_next = EL_R;
         end
         EL_R: begin
            op_a = w0_ff; op_b = w1_ff;
            plan_dst = DST_R; plan_next = FIN_R;
         end
         default: begin
            plan_next = MISS;
         end
      endcase
   end

   // decisions taken in a check step
   always_comb begin
      chk_hit    = 1'b0;
      chk_finish = 1'b1;
      chk_next   = step_ff;
      unique case (step_ff)
         SG_BRANCH: begin
            chk_finish = 1'b0;
            if (w1_ff <= 0) begin
               chk_next = SG_NA0;
            end else if (w1_ff >= w2_ff) begin
               chk_next = SG_NB0;
            end else begin
               chk_next = SG_CR0;
            end
         end
         EL_CHK: begin
            // a flat ellipse with no tolerance is a miss
            chk_finish = (a2_ff == 0) || (a3_ff == 0);
            chk_next   = EL_RXS;
         end
         QD_FIN: begin
            chk_hit = (a4_ff + tol_a >= a0_ff) && (a4_ff <= a1_ff + tol_a) &&
                      (a5_ff + tol_a >= a2_ff) && (a5_ff <= a3_ff + tol_a);
         end
         FIN_W0:  chk_hit = (q_ff <= w0_ff);
         FIN_R:   chk_hit = (q_ff <= r_ff);
         default: chk_hit = 1'b0;
      endcase
   end

   // next phase and step
   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      unique case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               step_in  = start_step;
               phase_in = start_check ? PH_CHECK : PH_LOAD;
            end
         end
         PH_LOAD: phase_in = PH_RUN;
         PH_RUN: begin
            if (mplier_ff == '0) begin
               phase_in = PH_STORE;
            end
         end
         PH_STORE: begin
            step_in = plan_next;
            if (plan_next == SG_BRANCH || plan_next == FIN_W0 || plan_next == FIN_R) begin
               phase_in = PH_CHECK;
            end else begin
               phase_in = PH_LOAD;
            end
         end
         PH_CHECK: begin
            if (chk_finish) begin
               phase_in = PH_DONE;
            end else begin
               step_in  = chk_next;
               phase_in = PH_LOAD;
            end
         end
         PH_DONE: begin
            if (!last_ff || out_free) begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      a0_in = a0_ff; a1_in = a1_ff; a2_in = a2_ff;
      a3_in = a3_ff; a4_in = a4_ff; a5_in = a5_ff;
      w0_in = w0_ff; w1_in = w1_ff; w2_in = w2_ff;
      q_in  = q_ff;  r_in  = r_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      neg_in    = neg_ff;
      last_in   = last_ff;
      item_hit_in   = item_hit_ff;
      hit_so_far_in = hit_so_far_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_hit_in    = rsp_hit_ff;

      mag_a = op_a[VW-1] ? -op_a : op_a;
      mag_b = op_b[VW-1] ? -op_b : op_b;

      unique case (plan_dst)
         DST_W0:  dst_old = w0_ff;
         DST_W1:  dst_old = w1_ff;
         DST_W2:  dst_old = w2_ff;
         DST_Q:   dst_old = q_ff;
         default: dst_old = r_ff;
      endcase
      store_base = (plan_cmb == CMB_SET) ? '0 : dst_old;
      store_prod = signed'(VW'(prod_ff));
      // fold the product sign into the add or subtract
      store_val  = (neg_ff ^ (plan_cmb == CMB_SUB)) ? store_base - store_prod
                                                     : store_base + store_prod;

      unique case (phase_ff)
         PH_IDLE: begin
            if (accept) begin
               last_in     = req_last_item;
               item_hit_in = 1'b0;
               unique case (mode_type'(req_mode))
                  MODE_ELLIPSE: begin
                     a0_in = px_e + px_e - ax_e - bx_e;
                     a1_in = py_e + py_e - ay_e - by_e;
                     a2_in = ext_x + tol_a + tol_a;
                     a3_in = ext_y + tol_a + tol_a;
                  end
                  MODE_QUAD: begin
                     a0_in = min2(min2(ax_e, bx_e), min2(cx_e, dx_e));
                     a1_in = max2(max2(ax_e, bx_e), max2(cx_e, dx_e));
                     a2_in = min2(min2(ay_e, by_e), min2(cy_e, dy_e));
                     a3_in = max2(max2(ay_e, by_e), max2(cy_e, dy_e));
                     a4_in = px_e;
                     a5_in = py_e;
                  end
                  default: begin
                     a0_in = bx_e - ax_e;
                     a1_in = by_e - ay_e;
                     a2_in = px_e - ax_e;
                     a3_in = py_e - ay_e;
                     a4_in = px_e - bx_e;
                     a5_in = py_e - by_e;
                  end
               endcase
            end
         end
         PH_LOAD: begin
            mcand_in  = (2*MW)'(mag_a[MW-1:0]);
            mplier_in = mag_b[MW-1:0];
            prod_in   = '0;
            neg_in    = op_a[VW-1] ^ op_b[VW-1];
         end
         PH_RUN: begin
            // retire one multiplier bit
            if (mplier_ff != '0) begin
               if (mplier_ff[0]) begin
                  prod_in = prod_ff + mcand_ff;
               end
               mcand_in  = {mcand_ff[2*MW-2:0], 1'b0};
               mplier_in = {1'b0, mplier_ff[MW-1:1]};
            end
         end
         PH_STORE: begin
            unique case (plan_dst)
               DST_W0:  w0_in = store_val;
               DST_W1:  w1_in = store_val;
               DST_W2:  w2_in = store_val;
               DST_Q:   q_in  = store_val;
               default: r_in  = store_val;
            endcase
         end
         PH_CHECK: begin
            if (chk_finish) begin
               item_hit_in = chk_hit;
            end
         end
         PH_DONE: begin
            if (!last_ff) begin
               hit_so_far_in = hit_so_far_ff || item_hit_ff;
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = hit_so_far_ff || item_hit_ff;
               hit_so_far_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         step_ff       <= MISS;
         hit_so_far_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         tol_ff        <= TOL_RESET;
      end else begin
         phase_ff      <= phase_in;
         step_ff       <= step_in;
         hit_so_far_ff <= hit_so_far_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (csr_write_enable) begin
            tol_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      a0_ff <= a0_in; a1_ff <= a1_in; a2_ff <= a2_in;
      a3_ff <= a3_in; a4_ff <= a4_in; a5_ff <= a5_in;
      w0_ff <= w0_in; w1_ff <= w1_in; w2_ff <= w2_in;
      q_ff  <= q_in;  r_ff  <= r_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      last_ff     <= last_in;
      item_hit_ff <= item_hit_in;
      rsp_hit_ff  <= rsp_hit_in;
   end

   // an accepted item always leaves idle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (phase_ff != PH_IDLE))
      else $error("item accepted but sequencer stayed idle");

   // a new response only comes from finishing a last item
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      (!$past(rsp_valid_ff) && rsp_valid_ff) |-> $past(phase_ff == PH_DONE && last_ff))
      else $error("response raised without a last item");

   // the run accumulator clears once a run is reported
   a_run_clear: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DONE && last_ff && out_free) |=> !hit_so_far_ff)
      else $error("run hit not cleared after response");

   // squared terms compared at the end are never negative
   a_cmp_nonneg: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_CHECK && step_ff == FIN_R) |-> (!q_ff[VW-1] && !r_ff[VW-1]))
      else $error("negative operand in final compare");

endmodule
`default_nettype wire

@@ verif/shape_point_hit_test_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shape_point_hit_test_unit_tb: self-checking bench for the point hit tester
// Streams runs of segment, ellipse, quad and unused-mode primitives through
// the request channel under random idling and response backpressure. An exact
// wide-integer predictor computes each run's hit flag, and the response
// transfers are checked in order. Several tolerance settings are covered,
// including zero and full scale.
// ----------------------------------------------------------------------------
module shape_point_hit_test_unit_tb;
   import sphit_pkg::*;

   localparam int CW = COORD_WIDTH_DEF;
   localparam logic [1:0] MODE_UNUSED = 2'd3;
   localparam int DRAIN_CYCLES = 700;     // longer than the slowest item
   localparam int STALL_LIMIT  = 20000;   // cycles with no transfer at all
   localparam int HOLD_CYCLES  = 3000;    // long response hold-off
   localparam int ITEMS_PER_PHASE = 285;

   // coordinate slots: point, first, second, third, fourth (x then y)
   typedef struct {
      logic [1:0]           mode;
      logic signed [CW-1:0] c [10];
      logic                 last;
   } prim_type;

   typedef logic signed [191:0] wide_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [TOL_WIDTH-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [1:0] req_mode = '0;
   logic signed [CW-1:0] req_point_x = '0, req_point_y = '0;
   logic signed [CW-1:0] req_first_x = '0, req_first_y = '0;
   logic signed [CW-1:0] req_second_x = '0, req_second_y = '0;
   logic signed [CW-1:0] req_third_x = '0, req_third_y = '0;
   logic signed [CW-1:0] req_fourth_x = '0, req_fourth_y = '0;
   logic req_last_item = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;

   shape_point_hit_test_unit uut (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req_valid, .req_stall, .req_mode,
      .req_point_x, .req_point_y, .req_first_x, .req_first_y,
      .req_second_x, .req_second_y, .req_third_x, .req_third_y,
      .req_fourth_x, .req_fourth_y, .req_last_item,
      .rsp_valid, .rsp_stall, .rsp_hit
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   prim_type pending_prims [$];
   logic  expected_hits [$];
   logic [TOL_WIDTH-1:0] tolerance = TOL_RESET;  // predictor's copy
   logic run_hit = 1'b0;                         // OR of hits in current run
   int accepted_prims = 0;
   int error_count = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   prim_type cur;

   task automatic report_mismatch(input string msg);
      $display("ERROR at %0t: %s", $realtime, msg);
      error_count++;
   endtask

   // Exact hit decision for one primitive at the given tolerance.
   function automatic logic prim_hit(input prim_type p, input logic [TOL_WIDTH-1:0] tol);
      wide_type px, py, ax, ay, bx, by, t, dx, dy, wx, wy, t2, dot, l2, cr;
      wide_type u, v, rx2, ry2, rxs, rys, lhs;
      longint lox, hix, loy, hiy, x, y, tl, qx, qy;
      px = p.c[0]; py = p.c[1]; ax = p.c[2]; ay = p.c[3];
      bx = p.c[4]; by = p.c[5];
      t = {169'd0, tol};
      case (p.mode)
         MODE_SEGMENT: begin
            dx = bx - ax; dy = by - ay;
            wx = px - ax; wy = py - ay;
            t2 = t * t;
            dot = wx * dx + wy * dy;
            l2 = dx * dx + dy * dy;
            // clamp to the start, to the end, or measure off the line
            if (dot <= 0) return (wx * wx + wy * wy) <= t2;
            if (dot - l2 >= 0) begin
               wx = px - bx; wy = py - by;
               return (wx * wx + wy * wy) <= t2;
            end
            cr = wx * dy - wy * dx;
            return (cr * cr) <= (t2 * l2);
         end
         MODE_ELLIPSE: begin
            u = px + px - ax - bx;
            v = py + py - ay - by;
            rx2 = (bx >= ax ? bx - ax : ax - bx) + t + t;
            ry2 = (ay >= by ? ay - by : by - ay) + t + t;
            if (rx2 == 0 || ry2 == 0) return 1'b0;   // degenerate: miss
            rxs = rx2 * rx2; rys = ry2 * ry2;
            lhs = u * u * rys + v * v * rxs;
            return lhs <= rxs * rys;
         end
         MODE_QUAD: begin
            tl = longint'(tol);
            qx = p.c[0]; qy = p.c[1];
            lox = p.c[2]; hix = lox; loy = p.c[3]; hiy = loy;
            for (int k = 1; k < 4; k++) begin
               x = p.c[2 + 2 * k]; y = p.c[3 + 2 * k];
               if (x < lox) lox = x;
               if (x > hix) hix = x;
               if (y < loy) loy = y;
               if (y > hiy) hiy = y;
            end
            return qx + tl >= lox && qx <= hix + tl && qy + tl >= loy && qy <= hiy + tl;
         end
         default: return 1'b0;   // unused mode still joins the run as a miss
      endcase
   endfunction

   // Random coordinate: mostly near a base point, sometimes anywhere or at a rail.
   function automatic logic signed [CW-1:0] near(input logic signed [CW-1:0] base,
                                                 input int spread);
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 10) return CW'($urandom);
      if (sel < 14) return sel[0] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      return base + CW'($urandom_range(0, 2 * spread) - spread);
   endfunction

   function automatic prim_type make_prim(input logic signed [CW-1:0] qx,
                                          input logic signed [CW-1:0] qy,
                                          input logic last, input int spread);
      prim_type p;
      int sel;
      sel = $urandom_range(0, 99);
      p.mode = sel < 38 ? MODE_SEGMENT : sel < 68 ? MODE_ELLIPSE :
               sel < 95 ? MODE_QUAD : MODE_UNUSED;
      p.c[0] = qx; p.c[1] = qy;
      for (int i = 2; i < 10; i++) p.c[i] = near(i[0] ? qy : qx, spread);
      // single-point strokes and flat boxes now and then
      if ($urandom_range(0, 9) == 0) begin
         p.c[4] = p.c[2]; p.c[5] = p.c[3];
      end
      p.last = last;
      return p;
   endfunction

   function automatic prim_type dir(input logic [1:0] m, input int v [10], input logic last);
      prim_type p;
      p.mode = m;
      for (int i = 0; i < 10; i++) p.c[i] = CW'(v[i]);
      p.last = last;
      return p;
   endfunction

   task automatic add_random_runs(input int count);
      int n, len, spread;
      logic signed [CW-1:0] qx, qy;
      n = 0;
      while (n < count) begin
         len = $urandom_range(1, 4);
         qx = CW'($urandom); qy = CW'($urandom);
         spread = $urandom_range(0, 1) ? int'(tolerance) * 3 + 16 : $urandom_range(16, 70000);
         for (int i = 0; i < len; i++)
            pending_prims.push_back(make_prim(qx, qy, i == len - 1, spread));
         n += len;
      end
   endtask

   // Wait for every queued item and result, then let the last item retire.
   task automatic drain();
      while (pending_prims.size() != 0 || req_valid || expected_hits.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [TOL_WIDTH-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      tolerance = value;
   endtask

   localparam int MAXC = 8388607;
   localparam int MINC = -8388608;

   initial begin
      logic [TOL_WIDTH-1:0] tols [5];
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // Directed runs at the reset tolerance of one page unit.
      // point stroke at exactly the tolerance (hit), then one past it (miss)
      pending_prims.push_back(dir(MODE_SEGMENT, '{0,0,256,0,256,0,0,0,0,0}, 1));
      pending_prims.push_back(dir(MODE_SEGMENT, '{0,0,257,0,257,0,0,0,0,0}, 1));
      // beyond the start, beyond the end, and beside the interior
      pending_prims.push_back(dir(MODE_SEGMENT, '{-300,0,0,0,1000,0,0,0,0,0}, 1));
      pending_prims.push_back(dir(MODE_SEGMENT, '{1200,0,0,0,1000,0,0,0,0,0}, 1));
      pending_prims.push_back(dir(MODE_SEGMENT, '{500,256,0,0,1000,0,0,0,0,0}, 1));
      pending_prims.push_back(dir(MODE_SEGMENT, '{500,257,0,0,1000,0,0,0,0,0}, 1));
      // rails: opposite corners of the coordinate space
      pending_prims.push_back(dir(MODE_SEGMENT,
         '{MAXC,MAXC,MINC,MINC,MAXC,MAXC,MINC,MAXC,MAXC,MINC}, 1));
      pending_prims.push_back(dir(MODE_SEGMENT,
         '{MINC,MAXC,MAXC,MINC,MINC,MINC,0,0,0,0}, 1));
      // ellipse: center, edge, swapped edges, outside, full span
      pending_prims.push_back(dir(MODE_ELLIPSE, '{500,500,0,0,1000,1000,0,0,0,0}, 1));
      pending_prims.push_back(dir(MODE_ELLIPSE, '{1256,500,0,0,1000,1000,0,0,0,0}, 1));
      pending_prims.push_back(dir(MODE_ELLIPSE, '{500,500,1000,1000,0,0,0,0,0,0}, 1));
      pending_prims.push_back(dir(MODE_ELLIPSE, '{1257,500,0,0,1000,1000,0,0,0,0}, 1));
      pending_prims.push_back(dir(MODE_ELLIPSE, '{MAXC,0,MINC,MINC,MAXC,MAXC,0,0,0,0}, 1));
      // quad: two points inside the grown box near its left edge, rail corners
      pending_prims.push_back(dir(MODE_QUAD, '{-256,0,0,0,100,50,30,90,-5,10}, 1));
      pending_prims.push_back(dir(MODE_QUAD, '{-257,0,0,0,100,50,30,90,-5,10}, 1));
      pending_prims.push_back(dir(MODE_QUAD,
         '{MAXC,MINC,MINC,MAXC,MAXC,MINC,0,0,MINC,MINC}, 1));
      // unused mode alone, then a run where two misses and a hit are ORed
      pending_prims.push_back(dir(MODE_UNUSED, '{0,0,0,0,0,0,0,0,0,0}, 1));
      pending_prims.push_back(dir(MODE_UNUSED, '{0,0,0,0,0,0,0,0,0,0}, 0));
      pending_prims.push_back(dir(MODE_QUAD, '{5000,0,0,0,1,1,2,2,3,3}, 0));
      pending_prims.push_back(dir(MODE_SEGMENT, '{0,0,0,0,0,0,0,0,0,0}, 1));
      add_random_runs(ITEMS_PER_PHASE);
      drain();

      // Zero tolerance: degenerate ellipses and exact on-line points.
      write_tolerance('0);
      pending_prims.push_back(dir(MODE_ELLIPSE, '{0,0,0,-10,0,10,0,0,0,0}, 1));
      pending_prims.push_back(dir(MODE_ELLIPSE, '{0,0,-10,5,10,5,0,0,0,0}, 1));
      pending_prims.push_back(dir(MODE_SEGMENT, '{50,50,0,0,100,100,0,0,0,0}, 1));
      pending_prims.push_back(dir(MODE_QUAD, '{7,7,7,7,7,7,7,7,7,7}, 1));
      add_random_runs(ITEMS_PER_PHASE);
      drain();

      tols = '{TOL_WIDTH'(MAXC), TOL_WIDTH'(1), TOL_WIDTH'($urandom_range(2, 4096)),
               TOL_WIDTH'($urandom_range(4097, 8388606)), TOL_RESET};
      foreach (tols[i]) begin
         write_tolerance(tols[i]);
         add_random_runs(ITEMS_PER_PHASE);
         drain();
      end

      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   // Request driver: advance on each transfer, otherwise hold the payload.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            // predict on transfer; a result is due only at the last item
            run_hit = run_hit | prim_hit(cur, tolerance);
            if (cur.last) begin
               expected_hits.push_back(run_hit);
               run_hit = 1'b0;
            end
            accepted_prims++;
         end
         if (!req_valid || !req_stall) begin
            // idle with a chance of 29 in 100, except in a quiet stretch
            if (pending_prims.size() != 0 &&
                ((accepted_prims >= 800 && accepted_prims < 1100) ||
                 $urandom_range(0, 99) >= 29)) begin
               cur = pending_prims.pop_front();
               req_valid     <= 1'b1;
               req_mode      <= cur.mode;
               req_point_x   <= cur.c[0]; req_point_y  <= cur.c[1];
               req_first_x   <= cur.c[2]; req_first_y  <= cur.c[3];
               req_second_x  <= cur.c[4]; req_second_y <= cur.c[5];
               req_third_x   <= cur.c[6]; req_third_y  <= cur.c[7];
               req_fourth_x  <= cur.c[8]; req_fourth_y <= cur.c[9];
               req_last_item <= cur.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor: check each transfer against the oldest expected hit.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_hits.size() == 0)
               report_mismatch($sformatf("unexpected response, hit=%b", rsp_hit));
            else if (rsp_hit !== expected_hits[0]) begin
               report_mismatch($sformatf("hit=%b, expected %b", rsp_hit, expected_hits[0]));
               void'(expected_hits.pop_front());
            end else
               void'(expected_hits.pop_front());
         end
         // one long hold-off early on so the unit backs up into the sender
         if (!hold_done && accepted_prims >= 300) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else
            rsp_stall <= !(accepted_prims >= 800 && accepted_prims < 1100) &&
                         $urandom_range(0, 99) < 29;
      end
   end

   // Watchdog: drop the run if nothing moves for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= STALL_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

endmodule

@@ shape_point_hit_test_unit.f @@
hdl/sphit_pkg.sv
hdl/shape_point_hit_test_unit.sv
verif/shape_point_hit_test_unit_tb.sv
